FILE: design/ttg_pkg.sv
// ttg_pkg: shared types and constants for the text to glyph offset core
// used by ttg_ctrl, ttg_datapath and text_to_glyph_offset_core; no dependencies
package ttg_pkg;

  localparam int CODE_W   = 16;
  localparam int OFFS_W   = 23;
  localparam int STAT_W   = 2;
  localparam int GLYPH_W  = 9;   // ceil(63/8)*63 = 504 fits
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = 8;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_PAIR = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNSUP    = 2'd2;

  // encoding modes
  localparam logic [1:0] MODE_UTF8   = 2'd0;
  localparam logic [1:0] MODE_GBK    = 2'd1;
  localparam logic [1:0] MODE_GB2312 = 2'd2;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_FONT_SIZE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ENCODING  = 2'd1;

  // utf-8 sequence classes
  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_TWO   = 2'd1;
  localparam logic [1:0] CLS_THREE = 2'd2;
  localparam logic [1:0] CLS_FOUR  = 2'd3;

  localparam logic [GLYPH_W-1:0] GLYPH_RESET = 9'd32;  // 16 px font

  typedef struct packed {
    logic accept;    // input transaction this cycle
    logic load_out;  // move product into the output register
  } ttg_cmd_t;

  typedef struct packed {
    logic has_result;  // current byte completes a character
  } ttg_stat_t;

  // glyph bytes for a font size: ceil(size/8) * size
  function automatic logic [GLYPH_W-1:0] glyph_bytes(input logic [5:0] size);
    logic [6:0] rnd;
    logic [9:0] prod;
    rnd  = {1'b0, size} + 7'd7;
    prod = rnd[6:3] * size;
    return prod[GLYPH_W-1:0];
  endfunction

endpackage

FILE: design/text_to_glyph_offset_core.sv
// text_to_glyph_offset_core: top level of the text to glyph offset core
// instantiates ttg_ctrl and ttg_datapath; depends on ttg_pkg
//
// usage
//   input channel (in_valid/in_ready, text_byte): one raw text byte per
//   transaction; utf-8 (1 to 3 byte), gbk pairs or gb2312 pairs, chosen by
//   the encoding register. a zero byte ends a string and drops any partial
//   sequence without a result.
//   output channel (out_valid/out_ready): one transaction per completed
//   character with char_code, glyph_offset and status.
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
//   font size, index 1 the encoding mode; always ready; to be written only
//   while the core is idle (unchecked). mode writes clear partial sequences.
// timing
//   a byte that completes nothing is simply taken. a completing byte is
//   decoded into the payload registers, then its cell index times glyph
//   bytes goes to the output; the input is not taken in the multiply step.
//   a stalled output holds its result; the next byte is still taken, and a
//   second result waits in the multiply step until the output frees.
// reset: font size 16, utf-8 mode, no partial sequence, output empty
module text_to_glyph_offset_core (
  input  logic                          clk,
  input  logic                          rst,
  // byte input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    text_byte,
  // character output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ttg_pkg::CODE_W-1:0]    char_code,
  output logic [ttg_pkg::OFFS_W-1:0]    glyph_offset,
  output logic [ttg_pkg::STAT_W-1:0]    status,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ttg_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [ttg_pkg::CDATA_W-1:0]   cfg_data
);
  import ttg_pkg::*;

  ttg_cmd_t  cmd;
  ttg_stat_t stat;

  // register writes never stall
  assign cfg_ready = 1'b1;

  ttg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ttg_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .text_byte    (text_byte),
    .cmd          (cmd),
    .stat         (stat),
    .char_code    (char_code),
    .glyph_offset (glyph_offset),
    .status       (status)
  );

endmodule

FILE: design/ttg_ctrl.sv
// ttg_ctrl: controller for the text to glyph offset core
// owns the input/output handshakes; depends on ttg_pkg
module ttg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ttg_pkg::ttg_stat_t stat,
  output ttg_pkg::ttg_cmd_t  cmd
);
  import ttg_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_MUL  = 1'b1;

  logic state, state_next;
  logic out_valid_next;

  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd.accept    = in_valid && in_ready;
    cmd.load_out  = (state == S_MUL) && (!out_valid || out_ready);
    state_next    = state;
    unique case (state)
      S_IDLE: if (cmd.accept && stat.has_result) state_next = S_MUL;
      S_MUL:  if (cmd.load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // a completing byte always starts the multiply step
  a_result_to_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && stat.has_result |=> state == S_MUL)
    else $error("completed character did not enter multiply step");

  // a new result only ever comes from the multiply step
  a_out_from_mul: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_MUL)
    else $error("result shown without multiply step");

endmodule

FILE: design/ttg_datapath.sv
// ttg_datapath: sequence assembly, cell index and glyph offset multiply
// holds config registers and sequence state; depends on ttg_pkg
module ttg_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ttg_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [ttg_pkg::CDATA_W-1:0]   cfg_data,
  input  logic [7:0]                    text_byte,
  input  ttg_pkg::ttg_cmd_t             cmd,
  output ttg_pkg::ttg_stat_t            stat,
  output logic [ttg_pkg::CODE_W-1:0]    char_code,
  output logic [ttg_pkg::OFFS_W-1:0]    glyph_offset,
  output logic [ttg_pkg::STAT_W-1:0]    status
);
  import ttg_pkg::*;

  // configuration
  logic [GLYPH_W-1:0] glyph;
  logic [1:0]         mode;

  // sequence state
  logic [1:0] bytes_pending, bytes_pending_next;
  logic [1:0] sequence_class, sequence_class_next;
  logic [7:0] first_byte, first_byte_next;
  logic [7:0] second_byte, second_byte_next;

  // decode results, registered for the multiply step
  logic [CODE_W-1:0] code_d, code_q;
  logic [15:0]       idx_d, idx_q;
  logic [STAT_W-1:0] stat_d, stat_q;
  logic [24:0]       product;

  always_comb begin
    logic [7:0]  hi_s, lo_s;
    logic [1:0]  pend_dec;
    logic [14:0] row_base;
    bytes_pending_next  = bytes_pending;
    sequence_class_next = sequence_class;
    first_byte_next     = first_byte;
    second_byte_next    = second_byte;
    stat.has_result     = 1'b0;
    code_d              = '0;
    idx_d               = '0;
    stat_d              = ST_OK;
    hi_s                = '0;
    lo_s                = '0;
    row_base            = '0;
    pend_dec            = bytes_pending - 2'd1;

    if (text_byte == 8'd0) begin
      // end of string drops any partial sequence
      bytes_pending_next  = '0;
      sequence_class_next = CLS_NONE;
      first_byte_next     = '0;
      second_byte_next    = '0;
    end else if (mode == MODE_GBK || mode == MODE_GB2312) begin
      if (bytes_pending == 2'd0) begin
        first_byte_next     = text_byte;
        sequence_class_next = CLS_NONE;
        bytes_pending_next  = 2'd1;
      end else begin
        bytes_pending_next = 2'd0;
        stat.has_result    = 1'b1;
        code_d             = {first_byte, text_byte};
        if (mode == MODE_GBK) begin
          if (first_byte < 8'h81 || first_byte == 8'hFF ||
              text_byte < 8'h40 || text_byte == 8'hFF) begin
            stat_d = ST_BAD_PAIR;
          end else begin
            hi_s     = first_byte - 8'h81;
            lo_s     = (text_byte < 8'h7F) ? text_byte - 8'h40 : text_byte - 8'h41;
            row_base = 15'(hi_s[6:0] * 8'd190);
            idx_d    = {1'b0, row_base} + {8'd0, lo_s};
          end
        end else begin
          // rows and cells wrap at 8 bits below 0xa1
          hi_s     = first_byte - 8'hA1;
          lo_s     = text_byte - 8'hA1;
          row_base = 15'(hi_s * 7'd94);
          idx_d    = {1'b0, row_base} + {8'd0, lo_s};
        end
      end
    end else if (bytes_pending == 2'd0) begin
      if (!text_byte[7]) begin
        stat.has_result = 1'b1;
        code_d          = {9'd0, text_byte[6:0]};
        idx_d           = code_d;
      end else begin
        first_byte_next = text_byte;
        if (!text_byte[5]) begin
          sequence_class_next = CLS_TWO;
          bytes_pending_next  = 2'd1;
        end else if (!text_byte[4]) begin
          sequence_class_next = CLS_THREE;
          bytes_pending_next  = 2'd2;
        end else begin
          sequence_class_next = CLS_FOUR;
          bytes_pending_next  = 2'd3;
        end
      end
    end else begin
      bytes_pending_next = pend_dec;
      case (sequence_class)
        CLS_TWO: begin
          sequence_class_next = CLS_NONE;
          stat.has_result     = 1'b1;
          code_d = {5'd0, first_byte[4:2], first_byte[1:0], text_byte[5:0]};
          idx_d  = code_d;
        end
        CLS_THREE: begin
          if (pend_dec != 2'd0) begin
            second_byte_next = text_byte;
          end else begin
            sequence_class_next = CLS_NONE;
            stat.has_result     = 1'b1;
            code_d = {first_byte[3:0], second_byte[5:2], second_byte[1:0],
                      text_byte[5:0]};
            idx_d  = code_d;
          end
        end
        CLS_FOUR: begin
          if (pend_dec == 2'd0) begin
            sequence_class_next = CLS_NONE;
            stat.has_result     = 1'b1;
            stat_d              = ST_UNSUP;
          end
        end
        default: bytes_pending_next = 2'd0;
      endcase
    end
  end

  // config and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph          <= GLYPH_RESET;
      mode           <= MODE_UTF8;
      bytes_pending  <= '0;
      sequence_class <= CLS_NONE;
      first_byte     <= '0;
      second_byte    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FONT_SIZE: glyph <= glyph_bytes(cfg_data[5:0]);
        REG_ENCODING: begin
          mode           <= cfg_data[1:0];
          bytes_pending  <= '0;
          sequence_class <= CLS_NONE;
          first_byte     <= '0;
          second_byte    <= '0;
        end
        default: ;
      endcase
    end else if (cmd.accept) begin
      bytes_pending  <= bytes_pending_next;
      sequence_class <= sequence_class_next;
      first_byte     <= first_byte_next;
      second_byte    <= second_byte_next;
    end
  end

  assign product = idx_q * glyph;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept && stat.has_result) begin
      code_q <= code_d;
      idx_q  <= idx_d;
      stat_q <= stat_d;
    end
    if (cmd.load_out) begin
      char_code    <= code_q;
      glyph_offset <= product[OFFS_W-1:0];
      status       <= stat_q;
    end
  end

  a_zero_index: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out && idx_q == 16'd0 |=> glyph_offset == '0)
    else $error("zero cell index gave nonzero offset");

  a_unsup_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && stat.has_result && stat_d == ST_UNSUP |-> idx_d == 16'd0 && code_d == '0)
    else $error("unsupported sequence carries a code");

endmodule
